[rtl/core/arme_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arme_pkg
// Shared types, codes and offset helpers for the address region map engine.
// ----------------------------------------------------------------------------
package arme_pkg;

  localparam int unsigned PAGE_BITS   = 12;
  localparam int unsigned PAGE_W      = 20;
  localparam int unsigned PEND_W      = 21;
  localparam logic [20:0] PAGE_LIMIT  = 21'h100000;
  localparam int unsigned DEF_MAX_REGIONS = 64;
  localparam logic [19:0] BASE_RESET  = 20'h40000;
  localparam logic [20:0] TOP_RESET   = 21'h0C0000;

  localparam logic [2:0] OP_MAP     = 3'd0;
  localparam logic [2:0] OP_UNMAP   = 3'd1;
  localparam logic [2:0] OP_PROTECT = 3'd2;
  localparam logic [2:0] OP_LOOKUP  = 3'd3;
  localparam logic [2:0] OP_FIND    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_TOP  = 1'b1;

  typedef struct packed {
    logic [31:0] off;
    logic [15:0] anon;
    logic [15:0] fid;
    logic [15:0] flags;
    logic [2:0]  prot;
    logic [20:0] pg_end;
    logic [19:0] pg_begin;
  } region_t;

  function automatic logic [31:0] adv_off(input logic [31:0] off, input logic [20:0] pages);
    adv_off = off + (32'(pages) << PAGE_BITS);
  endfunction

  function automatic logic compat(input region_t l, input region_t r);
    logic same;
    same = (l.prot == r.prot) && (l.flags == r.flags) && (l.fid == r.fid) &&
           (l.anon == r.anon);
    if (l.fid != 16'd0) begin
      same = same && (adv_off(l.off, l.pg_end - 21'(l.pg_begin)) == r.off);
    end
    compat = same;
  endfunction

endpackage
`default_nettype wire

[rtl/core/arme_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/address_region_map_engine_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_region_map_engine_top
// Page-granular region table with map, unmap, protect, lookup and free search.
// ----------------------------------------------------------------------------
// One request is handled at a time. The region table lives in two RAM banks:
// a change request streams the current bank region by region through one
// split-and-merge unit and writes the rebuilt table into the other bank, which
// becomes current only if it fits (else status table full). For each stored
// region a change reads it and then tries three piece slots (before, inside and
// after the request range); then come the end-of-table check, the final flush
// and the result, and a map also places the new region. Lookup and find free do
// one RAM read and one compare per region. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module address_region_map_engine_top
  import arme_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [19:0] in_begin_page,
  input  wire logic [20:0] in_end_page,
  input  wire logic [20:0] in_page_count,
  input  wire logic [2:0]  in_prot_bits,
  input  wire logic [15:0] in_map_flags,
  input  wire logic [15:0] in_file_id,
  input  wire logic signed [31:0] in_file_offset,
  input  wire logic [15:0] in_shared_anon_id,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  out_status,
  output      logic [19:0] out_found_begin_page,
  output      logic [20:0] out_found_end_page,
  output      logic [2:0]  out_found_prot,
  output      logic [15:0] out_found_flags,
  output      logic [15:0] out_found_file_id,
  output      logic signed [31:0] out_found_offset,
  output      logic [15:0] out_found_anon_id,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  localparam int unsigned AW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned KW = $clog2(MAX_REGIONS + 4);
  localparam int unsigned RW = $bits(region_t);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_PIECE = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // configuration
  logic [19:0] base_r;
  logic [20:0] top_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_TOP) ? {11'd0, top_r} : {12'd0, base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      top_r  <= TOP_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_BASE) begin
        base_r <= cfg_pwdata[19:0];
      end else begin
        top_r <= cfg_pwdata[20:0];
      end
    end
  end

  // control and working registers
  logic [2:0]    state_r, state_nxt;
  logic          bank_r, bank_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic          ins_r, ins_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [19:0]   key_r, key_nxt;
  logic [20:0]   cb_r, cb_nxt;
  logic [20:0]   ce_r, ce_nxt;
  logic [20:0]   cnt_r, cnt_nxt;
  logic [20:0]   cand_r, cand_nxt;
  region_t       new_r, new_nxt;
  region_t       pend_r, pend_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  region_t       res_r, res_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  region_t       out_r, out_nxt;

  // RAM banks
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  region_t       wr_data;
  logic          rd_en;
  logic [RW-1:0] rdata0, rdata1;
  region_t       cur;

  arme_ram #(.WIDTH(RW), .DEPTH(MAX_REGIONS)) u_bank0 (
    .clk  (clk),
    .we   (wr_en && bank_r),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en && !bank_r),
    .raddr(idx_r[AW-1:0]),
    .rdata(rdata0)
  );

  arme_ram #(.WIDTH(RW), .DEPTH(MAX_REGIONS)) u_bank1 (
    .clk  (clk),
    .we   (wr_en && !bank_r),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en && bank_r),
    .raddr(idx_r[AW-1:0]),
    .rdata(rdata1)
  );

  assign cur = bank_r ? region_t'(rdata1) : region_t'(rdata0);

  // piece selection for the region under the cursor
  logic        overlap;
  logic [20:0] lo, hi, cur_b21;
  logic        piece_has;
  region_t     piece;
  logic        is_change;
  logic [21:0] cand_sum;
  logic [20:0] top_sat;
  logic        fit_top;
  logic [20:0] in_end_sat;
  logic [21:0] in_unmap_end;
  logic [20:0] unmap_end_sat;

  assign cur_b21   = 21'(cur.pg_begin);
  assign overlap   = !((cur.pg_end <= cb_r) || (cur_b21 >= ce_r));
  assign lo        = (cur_b21 > cb_r) ? cur_b21 : cb_r;
  assign hi        = (cur.pg_end < ce_r) ? cur.pg_end : ce_r;
  assign is_change = (op_r == OP_MAP) || (op_r == OP_UNMAP) || (op_r == OP_PROTECT);
  assign cand_sum  = 22'(cand_r) + 22'(cnt_r);
  assign top_sat   = (top_r > PAGE_LIMIT) ? PAGE_LIMIT : top_r;
  assign fit_top   = cand_sum <= 22'(top_sat);

  assign in_end_sat    = (in_end_page > PAGE_LIMIT) ? PAGE_LIMIT : in_end_page;
  assign in_unmap_end  = 22'(in_begin_page) + 22'(in_page_count);
  assign unmap_end_sat = (in_unmap_end > 22'(PAGE_LIMIT)) ? PAGE_LIMIT : in_unmap_end[20:0];

  always_comb begin
    piece     = cur;
    piece_has = 1'b0;
    unique case (phase_r)
      2'd0: begin
        piece_has = overlap ? (cur_b21 < lo) : 1'b1;
        if (overlap) begin
          piece.pg_end = lo;
        end
      end
      2'd1: begin
        piece_has      = overlap && (op_r == OP_PROTECT);
        piece.pg_begin = lo[19:0];
        piece.pg_end   = hi;
        piece.prot     = new_r.prot;
        piece.off      = adv_off(cur.off, lo - cur_b21);
      end
      2'd2: begin
        piece_has      = overlap && (hi < cur.pg_end);
        piece.pg_begin = hi[19:0];
        piece.off      = adv_off(cur.off, hi - cur_b21);
      end
      default: begin
        piece_has = 1'b0;
      end
    endcase
  end

  // shared split-and-merge unit: one span in per cycle
  logic    emit_en;
  region_t emit_span;
  logic    emit_merge;

  assign emit_merge = pend_v_r && (pend_r.pg_end == 21'(emit_span.pg_begin)) &&
                      compat(pend_r, emit_span);

  logic [KW-1:0] k_last;
  assign k_last  = k_r - KW'(1);
  assign wr_addr = k_last[AW-1:0];
  assign wr_data = pend_r;

  logic flush_en;
  logic tail_commit;
  logic full;

  assign full  = k_r > KW'(MAX_REGIONS);
  assign wr_en = pend_v_r && (k_last < KW'(MAX_REGIONS)) &&
                 ((emit_en && !emit_merge) || flush_en);

  always_comb begin
    state_nxt      = state_r;
    bank_nxt       = bank_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    phase_nxt      = phase_r;
    k_nxt          = k_r;
    pend_v_nxt     = pend_v_r;
    ins_nxt        = ins_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    cb_nxt         = cb_r;
    ce_nxt         = ce_r;
    cnt_nxt        = cnt_r;
    cand_nxt       = cand_r;
    new_nxt        = new_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_nxt        = res_r;
    out_status_nxt = out_status_r;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    emit_en        = 1'b0;
    emit_span      = new_r;
    flush_en       = 1'b0;
    tail_commit    = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt           = in_opcode;
          key_nxt          = in_begin_page;
          cnt_nxt          = in_page_count;
          cand_nxt         = 21'(base_r);
          new_nxt.pg_begin = in_begin_page;
          new_nxt.pg_end   = in_end_sat;
          new_nxt.prot     = in_prot_bits;
          new_nxt.flags    = in_map_flags;
          new_nxt.fid      = in_file_id;
          new_nxt.off      = in_file_offset;
          new_nxt.anon     = in_shared_anon_id;
          cb_nxt           = 21'(in_begin_page);
          ce_nxt           = in_end_sat;
          idx_nxt          = '0;
          phase_nxt        = 2'd0;
          k_nxt            = '0;
          pend_v_nxt       = 1'b0;
          ins_nxt          = 1'b0;
          res_status_nxt   = ST_OK;
          res_nxt          = '0;
          state_nxt        = S_DONE;
          unique case (in_opcode)
            OP_MAP, OP_PROTECT: begin
              if (in_end_sat > 21'(in_begin_page)) begin
                state_nxt = S_READ;
              end
            end
            OP_UNMAP: begin
              ce_nxt = unmap_end_sat;
              if ((in_page_count != 21'd0) && (unmap_end_sat > 21'(in_begin_page))) begin
                state_nxt = S_READ;
              end
            end
            OP_LOOKUP, OP_FIND: begin
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        if (idx_r < count_r) begin
          rd_en     = 1'b1;
          phase_nxt = 2'd0;
          state_nxt = S_PIECE;
        end else if (is_change) begin
          state_nxt = S_TAIL;
        end else if (op_r == OP_LOOKUP) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else begin
          // end of table: the gap runs open to the top bound
          if (fit_top && (cand_r < PAGE_LIMIT)) begin
            res_nxt.pg_begin = cand_r[19:0];
            res_nxt.pg_end   = cand_sum[20:0];
          end else begin
            res_status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_DONE;
        end
      end

      S_PIECE: begin
        if (op_r == OP_LOOKUP) begin
          if ((cur.pg_begin <= key_r) && (21'(key_r) < cur.pg_end)) begin
            res_nxt   = cur;
            state_nxt = S_DONE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_READ;
          end
        end else if (op_r == OP_FIND) begin
          if (cand_sum <= 22'(cur.pg_begin)) begin
            if (fit_top && (cand_r < PAGE_LIMIT)) begin
              res_nxt.pg_begin = cand_r[19:0];
              res_nxt.pg_end   = cand_sum[20:0];
            end else begin
              res_status_nxt = ST_NOTFOUND;
            end
            state_nxt = S_DONE;
          end else begin
            if (cur.pg_end > cand_r) begin
              cand_nxt = cur.pg_end;
            end
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_READ;
          end
        end else begin
          // place the new region ahead of the first piece that starts after it
          if (piece_has && (op_r == OP_MAP) && !ins_r &&
              (piece.pg_begin > new_r.pg_begin)) begin
            emit_en   = 1'b1;
            emit_span = new_r;
            ins_nxt   = 1'b1;
          end else begin
            if (piece_has) begin
              emit_en   = 1'b1;
              emit_span = piece;
            end
            if (phase_r == 2'd2) begin
              idx_nxt   = idx_r + CW'(1);
              state_nxt = S_READ;
            end else begin
              phase_nxt = phase_r + 2'd1;
            end
          end
        end
      end

      S_TAIL: begin
        if ((op_r == OP_MAP) && !ins_r) begin
          emit_en   = 1'b1;
          emit_span = new_r;
          ins_nxt   = 1'b1;
        end else begin
          flush_en    = 1'b1;
          tail_commit = 1'b1;
          pend_v_nxt  = 1'b0;
          if (full) begin
            res_status_nxt = ST_FULL;
          end else begin
            bank_nxt  = !bank_r;
            count_nxt = CW'(k_r);
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_nxt        = res_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // merge into the pending span or retire it and start a new one
    if (emit_en) begin
      if (emit_merge) begin
        pend_nxt.pg_end = emit_span.pg_end;
      end else begin
        pend_nxt   = emit_span;
        pend_v_nxt = 1'b1;
        k_nxt      = k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      phase_r     <= 2'd0;
      k_r         <= '0;
      pend_v_r    <= 1'b0;
      ins_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      pend_v_r    <= pend_v_nxt;
      ins_r       <= ins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    cb_r         <= cb_nxt;
    ce_r         <= ce_nxt;
    cnt_r        <= cnt_nxt;
    cand_r       <= cand_nxt;
    new_r        <= new_nxt;
    pend_r       <= pend_nxt;
    res_status_r <= res_status_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_r        <= out_nxt;
  end

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_found_begin_page = out_r.pg_begin;
  assign out_found_end_page   = out_r.pg_end;
  assign out_found_prot       = out_r.prot;
  assign out_found_flags      = out_r.flags;
  assign out_found_file_id    = out_r.fid;
  assign out_found_offset     = out_r.off;
  assign out_found_anon_id    = out_r.anon;

  // table never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REGIONS))
    else $error("region count above capacity");

  // RAM writes only come from the rebuild states
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_PIECE || state_r == S_TAIL))
    else $error("table write outside rebuild");

  // a commit that fits swaps the banks
  a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_commit && !full) |=> (bank_r != $past(bank_r)))
    else $error("bank not swapped on commit");

  // a table full answer leaves the table alone
  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_commit && full) |=> (bank_r == $past(bank_r) && count_r == $past(count_r)))
    else $error("table changed on overflow");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_NOTFOUND ||
                     out_status_r == ST_FULL))
    else $error("undefined status code");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the address region map engine: requests go in over
// valid/ready, a region-table predictor computes the response of each accepted
// request, and every response transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import arme_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam logic [2:0] ADDR_BASE = 3'd0;
  localparam logic [2:0] ADDR_TOP  = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [19:0] pg_begin;
    logic [20:0] pg_end;
    logic [20:0] cnt;
    logic [2:0]  prot;
    logic [15:0] flags;
    logic [15:0] fid;
    logic [31:0] off;
    logic [15:0] anon;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] fbegin;
    logic [20:0] fend;
    logic [2:0]  prot;
    logic [15:0] flags;
    logic [15:0] fid;
    logic [31:0] off;
    logic [15:0] anon;
  } response_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [19:0] in_begin_page;
  logic [20:0] in_end_page;
  logic [20:0] in_page_count;
  logic [2:0]  in_prot_bits;
  logic [15:0] in_map_flags;
  logic [15:0] in_file_id;
  logic signed [31:0] in_file_offset;
  logic [15:0] in_shared_anon_id;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [19:0] out_found_begin_page;
  logic [20:0] out_found_end_page;
  logic [2:0]  out_found_prot;
  logic [15:0] out_found_flags;
  logic [15:0] out_found_file_id;
  logic signed [31:0] out_found_offset;
  logic [15:0] out_found_anon_id;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  address_region_map_engine_top dut (.*);

  int errors = 0;
  int unsigned cycles = 0;
  bit calm = 0;
  bit hold_req = 0;

  // predicted table state and registers
  region_t regions[$];
  region_t pieces[$];
  logic [19:0] cfg_base = BASE_RESET;
  logic [20:0] cfg_top  = TOP_RESET;

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic [31:0] shift_off(logic [31:0] off, logic [20:0] pages);
    return off + ({11'd0, pages} << PAGE_BITS);
  endfunction

  function automatic void add_piece(region_t p);
    if (pieces.size() < DEF_MAX_REGIONS + 4) pieces.push_back(p);
  endfunction

  // split the table around [b, e); drop the inside or relabel it
  function automatic void carve(logic [19:0] b, logic [20:0] e, logic relabel,
                                logic [2:0] nprot);
    region_t r, p;
    logic [20:0] lo, hi;
    pieces.delete();
    foreach (regions[i]) begin
      r = regions[i];
      if (r.pg_end <= {1'b0, b} || {1'b0, r.pg_begin} >= e) begin
        add_piece(r);
        continue;
      end
      lo = (r.pg_begin > b) ? {1'b0, r.pg_begin} : {1'b0, b};
      hi = (r.pg_end < e) ? r.pg_end : e;
      if ({1'b0, r.pg_begin} < lo) begin
        p = r;
        p.pg_end = lo;
        add_piece(p);
      end
      if (relabel) begin
        p = r;
        p.pg_begin = lo[19:0];
        p.pg_end = hi;
        p.prot = nprot;
        p.off = shift_off(r.off, lo - {1'b0, r.pg_begin});
        add_piece(p);
      end
      if (hi < r.pg_end) begin
        p = r;
        p.pg_begin = hi[19:0];
        p.off = shift_off(r.off, hi - {1'b0, r.pg_begin});
        add_piece(p);
      end
    end
  endfunction

  function automatic logic mergeable(region_t l, region_t r);
    if (l.prot != r.prot || l.flags != r.flags || l.fid != r.fid || l.anon != r.anon)
      return 1'b0;
    if (l.fid != 16'd0 && shift_off(l.off, l.pg_end - {1'b0, l.pg_begin}) != r.off)
      return 1'b0;
    return 1'b1;
  endfunction

  // sort pieces, merge touching neighbors, commit if the result fits
  function automatic logic [1:0] rebuild();
    region_t t;
    region_t merged[$];
    int j;
    for (int i = 1; i < pieces.size(); i++) begin
      t = pieces[i];
      j = i;
      while (j > 0 && pieces[j-1].pg_begin > t.pg_begin) begin
        pieces[j] = pieces[j-1];
        j--;
      end
      pieces[j] = t;
    end
    foreach (pieces[i]) begin
      j = merged.size() - 1;
      if (j >= 0 && merged[j].pg_end == {1'b0, pieces[i].pg_begin} &&
          mergeable(merged[j], pieces[i]))
        merged[j].pg_end = pieces[i].pg_end;
      else
        merged.push_back(pieces[i]);
    end
    if (merged.size() > DEF_MAX_REGIONS) return ST_FULL;
    regions = merged;
    return ST_OK;
  endfunction

  function automatic response_t predict_response(request_t q);
    response_t o;
    region_t s;
    logic [20:0] e;
    logic [21:0] ue;
    longint unsigned cand, top_sat;
    logic done, ok;
    o = '0;
    e = (q.pg_end > PAGE_LIMIT) ? PAGE_LIMIT : q.pg_end;
    s.pg_begin = q.pg_begin;
    s.pg_end = e;
    s.prot = q.prot;
    s.flags = q.flags;
    s.fid = q.fid;
    s.off = q.off;
    s.anon = q.anon;
    case (q.op)
      OP_MAP: begin
        if (e > {1'b0, q.pg_begin}) begin
          carve(q.pg_begin, e, 1'b0, 3'd0);
          add_piece(s);
          o.status = rebuild();
        end
      end
      OP_UNMAP: begin
        ue = {2'b0, q.pg_begin} + {1'b0, q.cnt};
        if (ue > {1'b0, PAGE_LIMIT}) ue = {1'b0, PAGE_LIMIT};
        if (q.cnt != 21'd0 && ue > {2'b0, q.pg_begin}) begin
          carve(q.pg_begin, ue[20:0], 1'b0, 3'd0);
          o.status = rebuild();
        end
      end
      OP_PROTECT: begin
        if (e > {1'b0, q.pg_begin}) begin
          carve(q.pg_begin, e, 1'b1, q.prot);
          o.status = rebuild();
        end
      end
      OP_LOOKUP: begin
        o.status = ST_NOTFOUND;
        foreach (regions[i]) begin
          if (regions[i].pg_begin <= q.pg_begin && {1'b0, q.pg_begin} < regions[i].pg_end) begin
            o.status = ST_OK;
            o.fbegin = regions[i].pg_begin;
            o.fend = regions[i].pg_end;
            o.prot = regions[i].prot;
            o.flags = regions[i].flags;
            o.fid = regions[i].fid;
            o.off = regions[i].off;
            o.anon = regions[i].anon;
            break;
          end
        end
      end
      OP_FIND: begin
        cand = cfg_base;
        top_sat = (cfg_top < PAGE_LIMIT) ? cfg_top : PAGE_LIMIT;
        done = 1'b0;
        ok = 1'b0;
        foreach (regions[i]) begin
          if (!done) begin
            if (cand + q.cnt <= regions[i].pg_begin) begin
              done = 1'b1;
              ok = (cand + q.cnt <= top_sat);
            end else if (regions[i].pg_end > cand) begin
              cand = regions[i].pg_end;
            end
          end
        end
        if (!done) ok = (cand + q.cnt <= top_sat);
        if (ok && cand < PAGE_LIMIT) begin
          o.fbegin = cand[19:0];
          o.fend = 21'(cand + q.cnt);
        end else begin
          o.status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  class response_board;
    response_t awaited[$];

    function void note_request(request_t q);
      awaited.push_back(predict_response(q));
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task check_response(response_t got);
      response_t x;
      if (awaited.size() == 0) begin
        report("response with nothing awaited");
        return;
      end
      x = awaited.pop_front();
      if (got.status != x.status) report($sformatf("status %0d exp %0d", got.status, x.status));
      if (got.fbegin != x.fbegin) report($sformatf("begin %0h exp %0h", got.fbegin, x.fbegin));
      if (got.fend != x.fend) report($sformatf("end %0h exp %0h", got.fend, x.fend));
      if (got.prot != x.prot) report($sformatf("prot %0d exp %0d", got.prot, x.prot));
      if (got.flags != x.flags) report($sformatf("flags %0h exp %0h", got.flags, x.flags));
      if (got.fid != x.fid) report($sformatf("file id %0h exp %0h", got.fid, x.fid));
      if (got.off != x.off) report($sformatf("offset %0h exp %0h", got.off, x.off));
      if (got.anon != x.anon) report($sformatf("anon id %0h exp %0h", got.anon, x.anon));
    endtask
  endclass

  response_board board = new();

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_response({out_status, out_found_begin_page, out_found_end_page,
                            out_found_prot, out_found_flags, out_found_file_id,
                            out_found_offset, out_found_anon_id});
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // result receiver
  initial begin
    int unsigned st;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        st = idle_len();
        if (st == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (st - 1) @(posedge clk);
        end
      end
    end
  end

  task automatic send_request(request_t q);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= q.op;
    in_begin_page <= q.pg_begin;
    in_end_page <= q.pg_end;
    in_page_count <= q.cnt;
    in_prot_bits <= q.prot;
    in_map_flags <= q.flags;
    in_file_id <= q.fid;
    in_file_offset <= q.off;
    in_shared_anon_id <= q.anon;
    do @(posedge clk); while (!in_ready);
    board.note_request(q);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_BASE) cfg_base = data[19:0];
    else cfg_top = data[20:0];
  endtask

  function automatic request_t make_req(logic [2:0] op, logic [19:0] b, logic [20:0] e,
                                        logic [20:0] cnt, logic [2:0] prot,
                                        logic [15:0] flags, logic [15:0] fid,
                                        logic [31:0] off, logic [15:0] anon);
    request_t q;
    q = {op, b, e, cnt, prot, flags, fid, off, anon};
    return q;
  endfunction

  function automatic logic [19:0] clamp_page(longint unsigned p);
    return (p > 20'hFFFFF) ? 20'hFFFFF : p[19:0];
  endfunction

  // mostly well-formed requests clustered in a small window, some noise
  function automatic request_t random_req(logic [19:0] win);
    request_t q;
    int unsigned r, len;
    logic [2:0] op;
    logic [19:0] b;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      q = make_req(3'($urandom_range(0, 7)), 20'($urandom), 21'($urandom), 21'($urandom),
                   3'($urandom), 16'($urandom), 16'($urandom), $urandom, 16'($urandom));
      return q;
    end
    r = $urandom_range(0, 99);
    op = (r < 40) ? OP_MAP : (r < 55) ? OP_UNMAP : (r < 70) ? OP_PROTECT :
         (r < 85) ? OP_LOOKUP : OP_FIND;
    b = clamp_page(win + $urandom_range(0, 600));
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(1, 16);
    q = make_req(op, b, 21'(b) + 21'(len), 21'(len), 3'($urandom_range(0, 1)), 16'h0, 16'h0,
                 {b[19:0], 12'h0}, 16'h0);
    if (op == OP_FIND) q.cnt = ($urandom_range(0, 4) == 0) ? 21'($urandom_range(0, 2000))
                                                            : 21'($urandom_range(1, 40));
    if ($urandom_range(0, 3) == 0) q.flags = 16'($urandom);
    if ($urandom_range(0, 2) == 0) q.fid = 16'd3;
    if ($urandom_range(0, 4) == 0) q.off = $urandom;
    if ($urandom_range(0, 4) == 0) q.anon = 16'($urandom);
    if ($urandom_range(0, 5) == 0) q.prot = 3'($urandom);
    return q;
  endfunction

  initial begin
    request_t q;
    logic [19:0] base_val, win;
    logic [20:0] top_val;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_LOOKUP;
    in_begin_page <= '0;
    in_end_page <= '0;
    in_page_count <= '0;
    in_prot_bits <= '0;
    in_map_flags <= '0;
    in_file_id <= '0;
    in_file_offset <= '0;
    in_shared_anon_id <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, merges, splits, wrapping offsets, saturation
    calm = 1;
    send_request(make_req(OP_LOOKUP, 20'd0, 21'd0, 21'd0, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_FIND, 20'd0, 21'd0, 21'd0, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_FIND, 20'd0, 21'd0, 21'h1FFFFF, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_MAP, 20'd1000, 21'd1010, 21'd0, 3'd3, 16'hFFFF, 16'h0,
                          32'h0, 16'hFFFF));
    send_request(make_req(OP_MAP, 20'd1010, 21'd1020, 21'd0, 3'd3, 16'hFFFF, 16'h0,
                          32'h1234, 16'hFFFF));
    send_request(make_req(OP_LOOKUP, 20'd1015, 21'd0, 21'd0, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_MAP, 20'd2000, 21'd2004, 21'd0, 3'd7, 16'h1, 16'd7,
                          32'h7FFFF000, 16'h0));
    send_request(make_req(OP_MAP, 20'd2004, 21'd2008, 21'd0, 3'd7, 16'h1, 16'd7,
                          32'h80003000, 16'h0));
    send_request(make_req(OP_PROTECT, 20'd2002, 21'd2006, 21'd0, 3'd5, 16'h0, 16'h0,
                          32'h0, 16'h0));
    send_request(make_req(OP_LOOKUP, 20'd2003, 21'd0, 21'd0, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_UNMAP, 20'd1005, 21'd0, 21'd3, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_UNMAP, 20'd1000, 21'd0, 21'd0, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_MAP, 20'd500, 21'd500, 21'd0, 3'd1, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_PROTECT, 20'd2007, 21'd2001, 21'd0, 3'd1, 16'h0, 16'h0,
                          32'h0, 16'h0));
    send_request(make_req(OP_MAP, 20'd1008, 21'd2003, 21'd0, 3'd1, 16'h0, 16'd9,
                          32'hFFFFF000, 16'h0));
    send_request(make_req(OP_LOOKUP, 20'd2006, 21'd0, 21'd0, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_MAP, 20'hFFFFF, 21'h1FFFFF, 21'd0, 3'd2, 16'h0, 16'h0,
                          32'h0, 16'h0));
    send_request(make_req(OP_LOOKUP, 20'hFFFFF, 21'd0, 21'd0, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(OP_UNMAP, 20'hFFFF0, 21'd0, 21'h1FFFFF, 3'd0, 16'h0, 16'h0,
                          32'h0, 16'h0));
    send_request(make_req(OP_MAP, 20'd262144, 21'd262200, 21'd0, 3'd0, 16'h0, 16'h0,
                          32'h0, 16'h0));
    send_request(make_req(OP_FIND, 20'd0, 21'd0, 21'd10, 3'd0, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(3'd5, 20'hABCDE, 21'h1ABCD, 21'd77, 3'd6, 16'h55, 16'h66,
                          32'h77, 16'h88));
    send_request(make_req(3'd6, 20'd1, 21'd2, 21'd3, 3'd4, 16'h0, 16'h0, 32'h0, 16'h0));
    send_request(make_req(3'd7, 20'd1015, 21'd1030, 21'd5, 3'd1, 16'h0, 16'h0, 32'h0, 16'h0));
    calm = 0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin base_val = 20'd0; top_val = PAGE_LIMIT; end
        1: begin base_val = 20'hFFFFF; top_val = 21'h1FFFFF; end
        2: begin
          base_val = 20'($urandom_range(0, 20'hFFFFF - 1000));
          top_val = 21'(base_val) + 21'($urandom_range(0, 800));
        end
        default: begin base_val = BASE_RESET; top_val = 21'd0; end
      endcase
      cfg_write(ADDR_BASE, {12'h0, base_val});
      cfg_write(ADDR_TOP, {11'h0, top_val});
      win = (base_val > 20'hFFC00) ? 20'hFFC00 : base_val;
      // fill the table past its capacity with one-page islands
      if (ph == 2) begin
        for (int k = 0; k < 70; k++)
          send_request(make_req(OP_MAP, win + 20'(2 * k), 21'(win) + 21'(2 * k + 1), 21'd0,
                                3'(k), 16'(k), 16'h0, 32'h0, 16'h0));
        send_request(make_req(OP_PROTECT, win, 21'(win) + 21'd140, 21'd0, 3'd6, 16'h0, 16'h0,
                              32'h0, 16'h0));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        calm = (n < 30);
        if (ph == 1 && n == 60) hold_req = 1;
        send_request(random_req(win));
      end
      calm = 0;
      drain();
    end

    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[address_region_map_engine_top.f]
rtl/core/arme_pkg.sv
rtl/core/arme_ram.sv
rtl/core/address_region_map_engine_top.sv
tb/sv/tb.sv
